// File: hdl/b64s_pkg.sv
// Shared types, constants and character-mapping functions for the base64url stream codec.
package b64s_pkg;

   // Most results that one input beat can produce (last encode beat with padding)
   localparam int unsigned MaxResults = 4;
   localparam int unsigned CountWidth = $clog2(MaxResults + 1);
   localparam int unsigned SlotWidth  = $clog2(MaxResults);

   localparam logic [7:0] PadChar = 8'h3D;

   // Configuration register indexes
   localparam logic CSR_DECODE_DIRECTION = 1'b0;
   localparam logic CSR_PAD_ENABLE       = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_has_data;
      logic       out_last;
      logic       out_bad_char;
   } rsp_type;

   // All results of one input beat, slot 0 first
   typedef struct packed {
      rsp_type [MaxResults-1:0] item;
      logic [CountWidth-1:0]    count;
   } group_type;

   typedef struct packed {
      logic [1:0] phase;
      logic [5:0] carry;
   } codec_state_type;

   // Map a 6-bit value to its URL-safe alphabet character
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] ch;
      if (v < 6'd26) begin
         ch = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         ch = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         ch = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         ch = 8'h2D;
      end else begin
         ch = 8'h5F;
      end
      return ch;
   endfunction

   // Map a character of either alphabet to its value; {bad, value}, bad chars give 63
   function automatic logic [6:0] char_value(input logic [7:0] c);
      logic [7:0] diff;
      logic [6:0] res;
      diff = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
         diff = c - 8'h41;
         res  = {1'b0, diff[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         diff = c - 8'h61 + 8'd26;
         res  = {1'b0, diff[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         diff = c - 8'h30 + 8'd52;
         res  = {1'b0, diff[5:0]};
      end else if (c == 8'h2D || c == 8'h2B) begin
         res = {1'b0, 6'd62};
      end else if (c == 8'h5F || c == 8'h2F) begin
         res = {1'b0, 6'd63};
      end else begin
         res = {1'b1, 6'd63};
      end
      return res;
   endfunction

endpackage

// File: hdl/b64s_core.sv
// Single-pass conversion of one beat into its group of results and the next codec state.
module b64s_core (
   input  b64s_pkg::req_type         item,
   input  b64s_pkg::codec_state_type state_cur,
   input  logic                      decode_direction,
   input  logic                      pad_enable,
   output b64s_pkg::group_type       group,
   output b64s_pkg::codec_state_type state_nxt
);
   import b64s_pkg::*;

   logic [CountWidth-1:0] n;
   logic [SlotWidth-1:0]  last_slot;
   logic [1:0]            ph;
   logic [6:0]            cv;
   logic [5:0]            v;
   logic                  bad;
   logic [5:0]            c;

   always_comb begin
      n         = '0;
      group     = '0;
      state_nxt = state_cur;
      bad       = 1'b0;
      cv        = char_value(item.in_byte);
      v         = cv[5:0];
      c         = state_cur.carry;
      ph        = state_cur.phase;
      last_slot = '0;

      if (!decode_direction) begin
         // Encode: a phase of three restarts the group
         if (ph == 2'd3) begin
            ph = 2'd0;
         end
         case (ph)
            2'd0: begin
               group.item[0].out_byte = sextet_char(item.in_byte[7:2]);
               group.item[0].out_has_data = 1'b1;
               n = CountWidth'(1);
               state_nxt.carry = {item.in_byte[1:0], 4'b0000};
               state_nxt.phase = 2'd1;
            end
            2'd1: begin
               group.item[0].out_byte = sextet_char(c | {2'b00, item.in_byte[7:4]});
               group.item[0].out_has_data = 1'b1;
               n = CountWidth'(1);
               state_nxt.carry = {item.in_byte[3:0], 2'b00};
               state_nxt.phase = 2'd2;
            end
            default: begin
               group.item[0].out_byte = sextet_char(c | {4'b0000, item.in_byte[7:6]});
               group.item[0].out_has_data = 1'b1;
               group.item[1].out_byte = sextet_char(item.in_byte[5:0]);
               group.item[1].out_has_data = 1'b1;
               n = CountWidth'(2);
               state_nxt.carry = 6'd0;
               state_nxt.phase = 2'd0;
            end
         endcase
         // Flush a short final group, then pad
         if (item.in_last && state_nxt.phase != 2'd0) begin
            group.item[1].out_byte = sextet_char(state_nxt.carry);
            group.item[1].out_has_data = 1'b1;
            n = CountWidth'(2);
            if (pad_enable) begin
               group.item[2].out_byte = PadChar;
               group.item[2].out_has_data = 1'b1;
               n = CountWidth'(3);
               if (state_nxt.phase == 2'd1) begin
                  group.item[3].out_byte = PadChar;
                  group.item[3].out_has_data = 1'b1;
                  n = CountWidth'(4);
               end
            end
         end
      end else begin
         // Decode: pad characters are skipped and leave the phase alone
         if (item.in_byte != PadChar) begin
            bad = cv[6];
            case (ph)
               2'd0: begin
                  state_nxt.carry = v;
                  state_nxt.phase = 2'd1;
               end
               2'd1: begin
                  group.item[0].out_byte = {c, v[5:4]};
                  n = CountWidth'(1);
                  state_nxt.carry = {2'b00, v[3:0]};
                  state_nxt.phase = 2'd2;
               end
               2'd2: begin
                  group.item[0].out_byte = {c[3:0], v[5:2]};
                  n = CountWidth'(1);
                  state_nxt.carry = {4'b0000, v[1:0]};
                  state_nxt.phase = 2'd3;
               end
               default: begin
                  group.item[0].out_byte = {c[1:0], v};
                  n = CountWidth'(1);
                  state_nxt.carry = 6'd0;
                  state_nxt.phase = 2'd0;
               end
            endcase
            group.item[0].out_has_data = 1'b1;
            group.item[0].out_bad_char = bad;
         end
         // Close a stream whose last beat gave no byte with an empty result
         if (item.in_last && n == '0) begin
            group.item[0].out_byte     = 8'h00;
            group.item[0].out_has_data = 1'b0;
            group.item[0].out_bad_char = bad;
            n = CountWidth'(1);
         end
      end

      // Mark the final result and restart the stream state
      if (item.in_last) begin
         last_slot = n[SlotWidth-1:0] - SlotWidth'(1);
         group.item[last_slot].out_last = 1'b1;
         state_nxt = '0;
      end
      group.count = n;
   end

endmodule

// File: hdl/b64s_drain.sv
// Result buffer for one beat's group; sends one result per cycle if rsp_ready is high.
module b64s_drain (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   output logic                load_ready,
   input  b64s_pkg::group_type load_group,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output b64s_pkg::rsp_type   rsp_data
);
   import b64s_pkg::*;

   group_type             group_ff;
   logic [CountWidth-1:0] remaining_ff, remaining_in;
   logic [SlotWidth-1:0]  slot_ff, slot_in;

   // Free when empty, or once the last held result leaves this cycle
   assign load_ready = (remaining_ff == '0) ||
                       (remaining_ff == CountWidth'(1) && rsp_ready);
   assign rsp_valid  = (remaining_ff != '0);
   assign rsp_data   = group_ff.item[slot_ff];

   // Advance through the group, or load the next one
   always_comb begin
      remaining_in = remaining_ff;
      slot_in      = slot_ff;
      if (load_valid && load_ready) begin
         remaining_in = load_group.count;
         slot_in      = '0;
      end else if (rsp_valid && rsp_ready) begin
         remaining_in = remaining_ff - CountWidth'(1);
         slot_in      = slot_ff + SlotWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         slot_ff      <= '0;
      end else begin
         remaining_ff <= remaining_in;
         slot_ff      <= slot_in;
      end
   end

   // Hold payload; no reset needed
   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         group_ff <= load_group;
      end
   end

endmodule

// File: hdl/base64url_stream_codec_unit.sv
// Top level of the base64url stream codec: input register, state, config and result buffer.
//
// Usage:
//   req_valid/req_ready/req_data carry one byte (or character) per beat with an
//   end-of-stream flag. rsp_valid/rsp_ready/rsp_data return encoded characters or
//   decoded bytes, each with has_data, last and bad_char flags.
//   csr_write_en/csr_index/csr_wdata set decode_direction (index 0) and
//   pad_enable (index 1); write only while no stream is in flight.
// Path: an accepted beat is held in the input register, converted by the core
//   as the result buffer loads its group, and sent from that buffer on
//   rsp_data.
// Throughput: one beat per cycle while rsp_ready is high and each beat yields
//   at most one result. A beat that yields several results holds the result
//   buffer until the single result port has sent them all; encoding averages four results per three bytes.
// Reset: clears the stream state, empties the input register and result
//   buffer, sets decode_direction to 0 and pad_enable to 1.
// Stall: with rsp_ready low the result buffer holds its group, the input
//   register fills with the next beat, and req_ready then drops.
module base64url_stream_codec_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b64s_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b64s_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic              csr_wdata
);
   import b64s_pkg::*;

   req_type         req_ff;
   logic            req_valid_ff, req_valid_in;
   codec_state_type state_ff, state_in;
   logic            decode_ff, decode_in;
   logic            pad_ff, pad_in;
   group_type       group;
   logic            load_ready;
   logic            load_fire;

   assign load_fire = req_valid_ff && load_ready;
   assign req_ready = !req_valid_ff || load_ready;

   b64s_core u_core (
      .item             (req_ff),
      .state_cur        (state_ff),
      .decode_direction (decode_ff),
      .pad_enable       (pad_ff),
      .group            (group),
      .state_nxt        (state_in)
   );

   b64s_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_valid_ff),
      .load_ready (load_ready),
      .load_group (group),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // Decode configuration writes
   always_comb begin
      decode_in = decode_ff;
      pad_in    = pad_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DECODE_DIRECTION: decode_in = csr_wdata;
            CSR_PAD_ENABLE:       pad_in    = csr_wdata;
            default:              decode_in = decode_ff;
         endcase
      end
   end

   // Track input register occupancy
   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_valid && req_ready) begin
         req_valid_in = 1'b1;
      end else if (load_fire) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         state_ff     <= '0;
         decode_ff    <= 1'b0;
         pad_ff       <= 1'b1;
      end else begin
         req_valid_ff <= req_valid_in;
         decode_ff    <= decode_in;
         pad_ff       <= pad_in;
         if (load_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // A group never exceeds the result buffer
   assert property (@(posedge clock) disable iff (reset)
      load_fire |-> (group.count <= CountWidth'(MaxResults)))
      else $error("result group larger than buffer");

   // Encoding always produces at least one character
   assert property (@(posedge clock) disable iff (reset)
      (load_fire && !decode_ff) |-> (group.count != '0))
      else $error("encode beat produced no result");

   // A final beat leaves the stream state cleared
   assert property (@(posedge clock) disable iff (reset)
      (load_fire && req_ff.in_last) |=> (state_ff == '0))
      else $error("stream state not cleared after last beat");

   // A final beat always ends with a result flagged last
   assert property (@(posedge clock) disable iff (reset)
      (load_fire && req_ff.in_last) |->
         group.item[group.count[SlotWidth-1:0] - SlotWidth'(1)].out_last)
      else $error("last beat without a last result");

endmodule
